### rtl/gb3_pkg.sv
// Shared constants, types and helpers for the 3x3 Gaussian blur stream.
// No dependencies; imported by every rtl module of the block.
package gb3_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 9;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 13;
    localparam int PADDR_W    = 3;
    localparam int SUM_W      = 12;
    localparam int CSUM_W     = 10;

    // result queue
    localparam int Q_DEPTH = 3;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // register map (index = paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } gb3_col_t;

    // stage-1 control, registered at the accept edge
    typedef struct packed {
        logic             access;     // line store read-modify-write + window shift
        logic             res;        // this transaction produces a result
        logic             left_rep;   // left column replicated from centre
        logic             right_hold; // end-of-row result: right column = centre
        logic             top_dup;    // second row: top replicated from middle
        logic             use_pix;    // real pixel; else bottom replicated
        logic             last;       // final result of the plane
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pix;
    } gb3_s1_t;

    function automatic logic [CSUM_W-1:0] col_sum(input gb3_col_t c);
        col_sum = CSUM_W'(c.top) + {1'b0, c.mid, 1'b0} + CSUM_W'(c.bot);
    endfunction

endpackage

### rtl/gb3_regs.sv
// APB-style configuration registers: image width and height, clamped copies.
// Depends on gb3_pkg.
module gb3_regs
    import gb3_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                cfg_wr,
    output logic [WIDTH_W-1:0]  eff_width,
    output logic [HEIGHT_W-1:0] eff_height
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                idx;

    assign idx    = paddr[2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // out-of-range: 0 acts as 1, above max acts as max
    always_comb
    begin
        if (width_reg == '0)
            eff_width = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            eff_width = WIDTH_W'(MAX_WIDTH);
        else
            eff_width = width_reg;

        if (height_reg == '0)
            eff_height = HEIGHT_W'(1);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            eff_height = HEIGHT_W'(MAX_HEIGHT);
        else
            eff_height = height_reg;
    end

endmodule

### rtl/gb3_seq.sv
// Raster sequencer: row/column counters, transaction decode, stage-1 control
// register and input flow control. Depends on gb3_pkg.
module gb3_seq
    import gb3_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                command,
    input  logic [PIX_W-1:0]    pixel_in,
    output logic                src_stall,
    input  logic                cfg_wr,
    input  logic [WIDTH_W-1:0]  eff_width,
    input  logic [HEIGHT_W-1:0] eff_height,
    input  logic [QCNT_W-1:0]   q_count,
    output logic                rd_en,
    output logic [COL_W-1:0]    rd_addr,
    output gb3_s1_t             s1
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    gb3_s1_t          s1_reg, s1_next;

    logic             acc;
    logic             drop, eol, last, access, mid;
    logic [ROW_W-1:0] h_plus1;
    logic [COL_W:0]   col_inc;
    logic             wrap;

    // room for everything already in flight plus one more result
    assign src_stall = (QCNT_W'(q_count) + QCNT_W'(s1_reg.res)) >= QCNT_W'(Q_DEPTH);
    assign acc       = src_valid && !src_stall;

    assign h_plus1 = ROW_W'(eff_height) + ROW_W'(1);
    assign drop    = (command == CMD_DRAIN) && (row_reg < ROW_W'(eff_height));
    assign eol     = !drop && (col_reg == '0) && (row_reg >= ROW_W'(2));
    assign last    = eol && (row_reg == h_plus1);
    assign access  = !drop && !last;
    assign mid     = access && (col_reg != '0) && (row_reg != '0);
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
    assign wrap    = col_inc >= (COL_W+1)'(eff_width);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (acc)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (!drop)
            begin
                if (wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        s1_next.access     = acc && access;
        s1_next.res        = acc && (eol || mid);
        s1_next.left_rep   = eol ? (eff_width == WIDTH_W'(1)) : (col_reg == COL_W'(1));
        s1_next.right_hold = eol;
        s1_next.top_dup    = (row_reg == ROW_W'(1));
        s1_next.use_pix    = (row_reg < ROW_W'(eff_height));
        s1_next.last       = last;
        s1_next.addr       = col_reg;
        s1_next.pix        = pixel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            s1_reg  <= s1_next;
        end
    end

    assign rd_en   = acc && access;
    assign rd_addr = col_reg;
    assign s1      = s1_reg;

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && last) |=> (row_reg == '0 && col_reg == '0))
        else $error("plane end did not restart counters");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < (COL_W+1)'(eff_width)))
        else $error("column counter beyond image width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= h_plus1))
        else $error("row counter beyond drain limit");
`endif

endmodule

### rtl/gb3_line_store.sv
// Two line memories (read at accept, written back in the next cycle, with
// forwarding) and the 3x3 window registers. Depends on gb3_pkg.
module gb3_line_store
    import gb3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  gb3_s1_t          s1,
    output gb3_col_t         left,
    output gb3_col_t         centre,
    output gb3_col_t         right
);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [PIX_W-1:0] upper_rd_reg, lower_rd_reg;
    gb3_col_t         win_reg [3];
    gb3_col_t         new_col;
    logic             fwd;

    // new column from read data; row rules replicate the top and bottom edges
    assign new_col.mid = lower_rd_reg;
    assign new_col.top = s1.top_dup ? lower_rd_reg : upper_rd_reg;
    assign new_col.bot = s1.use_pix ? s1.pix : lower_rd_reg;

    // same entry written this cycle and read for the next transaction
    assign fwd = s1.access && (s1.addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (s1.access)
        begin
            upper_mem[s1.addr] <= new_col.mid;
            lower_mem[s1.addr] <= new_col.bot;
        end
        if (rd_en)
        begin
            upper_rd_reg <= fwd ? new_col.mid : upper_mem[rd_addr];
            lower_rd_reg <= fwd ? new_col.bot : lower_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (s1.access)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= new_col;
        end
    end

    // window as seen after this transaction's shift (or before, at row end)
    assign left   = s1.left_rep ? win_reg[2] : win_reg[1];
    assign centre = win_reg[2];
    assign right  = s1.right_hold ? win_reg[2] : new_col;

endmodule

### rtl/gb3_out.sv
// Weighted 3x3 sum and the result queue feeding the output channel.
// Depends on gb3_pkg.
module gb3_out
    import gb3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              push_last,
    input  gb3_col_t          left,
    input  gb3_col_t          centre,
    input  gb3_col_t          right,
    input  logic              dst_stall,
    output logic              dst_valid,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              frame_last,
    output logic [QCNT_W-1:0] q_count
);

    logic [PIX_W-1:0]  q_pix_reg  [Q_DEPTH];
    logic              q_last_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]  sum;
    logic              pop;

    assign sum = SUM_W'(col_sum(left)) + {1'b0, col_sum(centre), 1'b0}
               + SUM_W'(col_sum(right));

    assign dst_valid  = (count_reg != '0);
    assign pop        = dst_valid && !dst_stall;
    assign pixel_out  = q_pix_reg[rd_ptr_reg];
    assign frame_last = q_last_reg[rd_ptr_reg];
    assign q_count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_pix_reg[wr_ptr_reg]  <= sum[SUM_W-1:4];
            q_last_reg[wr_ptr_reg] <= push_last;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == QCNT_W'(Q_DEPTH)))
        else $error("result queue overflow");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("result queue count did not advance");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_stall) |=>
            (dst_valid && $stable(pixel_out) && $stable(frame_last)))
        else $error("stalled result changed");
`endif

endmodule

### rtl/gaussian_blur_3x3_stream_top.sv
// Top level of the 3x3 Gaussian blur stream (1-2-1 x 1-2-1, sum >> 4).
// Depends on gb3_pkg, gb3_regs, gb3_seq, gb3_line_store, gb3_out.
//
//  channel   handshake                   payload
//  --------  --------------------------  ------------------------------
//  src       src_valid / src_stall       command, pixel_in
//  dst       dst_valid / dst_stall       pixel_out, frame_last
//  cfg       psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One transaction per clock while src_stall is low; a result passes through the
// stage-1 control register and the result queue before it leaves. The line
// memories are read at the accept edge and written back on the next cycle, with
// forwarding when a one-pixel-wide image hits the same entry on consecutive transactions.
// src_stall rises only when the 3-entry result queue plus the result in flight
// would overflow, so only once dst has been stalled.
// Reset clears counters, window and queue; the line memories are not cleared
// and need no clearing pass (never-written entries never reach an output).
module gaussian_blur_3x3_stream_top
    import gb3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               src_valid,
    output logic               src_stall,
    input  logic               command,
    input  logic [PIX_W-1:0]   pixel_in,
    // output channel
    output logic               dst_valid,
    input  logic               dst_stall,
    output logic [PIX_W-1:0]   pixel_out,
    output logic               frame_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic                cfg_wr;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [QCNT_W-1:0]   q_count;
    logic                rd_en;
    logic [COL_W-1:0]    rd_addr;
    gb3_s1_t             s1;
    gb3_col_t            left, centre, right;

    // zero-wait-state register port
    assign pready = 1'b1;

    gb3_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cfg_wr     (cfg_wr),
        .eff_width  (eff_width),
        .eff_height (eff_height)
    );

    // counters decide per transaction: drop, end-of-row result, mid-row result
    gb3_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .command    (command),
        .pixel_in   (pixel_in),
        .src_stall  (src_stall),
        .cfg_wr     (cfg_wr),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .q_count    (q_count),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .s1         (s1)
    );

    // line memories and window: stage 1 of the pipeline
    gb3_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .s1      (s1),
        .left    (left),
        .centre  (centre),
        .right   (right)
    );

    // weighted sum into the result queue
    gb3_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1.res),
        .push_last  (s1.last),
        .left       (left),
        .centre     (centre),
        .right      (right),
        .dst_stall  (dst_stall),
        .dst_valid  (dst_valid),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .q_count    (q_count)
    );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for gaussian_blur_3x3_stream_top (3x3 1-2-1 blur, 8-bit plane).
// Depends on gb3_pkg for widths, command codes and the register map, and on the rtl top level.
module testbench;
    import gb3_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup. All inputs start at known values.
    // ------------------------------------------------------------------
    localparam int IDLE_LIMIT = 3000;   // cycles with no transaction anywhere
    localparam int SETTLE     = 4;      // results leave through the stage-1 register and the result queue

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    logic               command = CMD_PIXEL;
    logic [PIX_W-1:0]   pixel_in = '0;
    logic               dst_valid;
    logic               dst_stall = 1'b0;
    logic [PIX_W-1:0]   pixel_out;
    logic               frame_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gaussian_blur_3x3_stream_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .command    (command),
        .pixel_in   (pixel_in),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Blur predictor: its own copy of the line stores, window, raster
    // counters and geometry registers. Every accepted input transaction
    // is run through blur_step, which queues any pixel it should produce.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } blurred_px_t;

    blurred_px_t         blurred_queue[$];
    int unsigned         mismatches = 0;

    logic [PIX_W-1:0]    prev_row[MAX_WIDTH];    // two rows up
    logic [PIX_W-1:0]    last_row[MAX_WIDTH];    // one row up
    logic [PIX_W-1:0]    win[9];                 // 3 columns, oldest first, top first
    int unsigned         col_in = 0;
    int unsigned         row_in = 0;             // runs to height + 1 while flushing
    logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;

    initial
    begin
        foreach (prev_row[k]) prev_row[k] = '0;
        foreach (last_row[k]) last_row[k] = '0;
        foreach (win[k]) win[k] = '0;
    end

    // weighted column: top + 2*mid + bottom, column k of the window
    function automatic int unsigned col_weight(input int k);
        return 32'(win[3*k]) + 2 * 32'(win[3*k+1]) + 32'(win[3*k+2]);
    endfunction

    function automatic logic [PIX_W-1:0] blend(input int unsigned l, c, r);
        logic [31:0] s;
        s = l + 2 * c + r;
        return s[11:4];
    endfunction

    task automatic blur_step(input logic cmd, input logic [PIX_W-1:0] pix);
        int unsigned w, h, i, j;
        logic [PIX_W-1:0] lo, tp, bt;
        blurred_px_t px;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        i = row_in;
        j = col_in;
        // drain while the plane is still being fed: no effect at all
        if (cmd == CMD_DRAIN && i < h)
            return;
        if (j >= w)
            j = 0;
        // a new row closes the row two above: right edge replicated
        if (j == 0 && i >= 2)
        begin
            px.pixel = blend(col_weight((w == 1) ? 2 : 1), col_weight(2), col_weight(2));
            px.last  = (i == h + 1);
            blurred_queue.push_back(px);
            if (i == h + 1)
            begin
                col_in = 0;
                row_in = 0;
                return;
            end
        end
        // line store read-modify-write; top row replicated on row 1,
        // bottom row replicated once past the last input row
        lo = last_row[j];
        tp = (i == 1) ? lo : prev_row[j];
        bt = (i < h) ? pix : lo;
        prev_row[j] = lo;
        last_row[j] = bt;
        for (int k = 0; k < 6; k++)
            win[k] = win[k+3];
        win[6] = tp;
        win[7] = lo;
        win[8] = bt;
        if (j >= 1 && i >= 1)
        begin
            // left edge replicated for the first column of a row
            px.pixel = blend(col_weight((j == 1) ? 1 : 0), col_weight(1), col_weight(2));
            px.last  = 1'b0;
            blurred_queue.push_back(px);
        end
        j++;
        if (j >= w)
        begin
            j = 0;
            i++;
        end
        col_in = j;
        row_in = i;
    endtask

    // ------------------------------------------------------------------
    // Output checker: every accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        blurred_px_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (blurred_queue.size() == 0)
            begin
                $error("unexpected transaction: pixel_out %0d frame_last %0b",
                       pixel_out, frame_last);
                mismatches++;
            end
            else
            begin
                want = blurred_queue.pop_front();
                if (pixel_out !== want.pixel)
                begin
                    $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel_out);
                    mismatches++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0b, actual %0b", want.last, frame_last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: alternates quiet stretches, random dither
    // and solid stalls, each of random length, independent of the sender.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       dst_stall <= 1'b0;
            1:       dst_stall <= 1'($urandom_range(0, 1));
            default: dst_stall <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which no transaction happens on any port.
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. Items go out in bursts; between bursts valid drops for
    // a random gap. Payload is held until the transaction is accepted.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        @(negedge clk);
        src_valid <= 1'b1;
        command   <= cmd;
        pixel_in  <= pix;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        blur_step(cmd, pix);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
            @(negedge clk);
            src_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // all predicted results delivered, plus time for a trailing drain to settle
    task automatic wait_quiet();
        @(negedge clk);
        src_valid <= 1'b0;
        while (blurred_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle then access cycle.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // a write restarts the plane; stores and window keep their contents
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = value[WIDTH_W-1:0];
        else
            cfg_height = value[HEIGHT_W-1:0];
        col_in = 0;
        row_in = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata[%0d]: expected %0d, actual %0d", idx, want, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned wval, input int unsigned hval);
        wait_quiet();
        apb_write(REG_IMAGE_WIDTH, wval);
        check_register(REG_IMAGE_WIDTH, 32'(wval[WIDTH_W-1:0]));
        apb_write(REG_IMAGE_HEIGHT, hval);
        check_register(REG_IMAGE_HEIGHT, 32'(hval[HEIGHT_W-1:0]));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        check_register(REG_IMAGE_WIDTH, 32'(WIDTH_RESET));
        check_register(REG_IMAGE_HEIGHT, 32'(HEIGHT_RESET));
    endtask

    // zero width and height act as a 1x1 plane; early drain is ignored,
    // a pixel sent while flushing counts as a drain
    task automatic test_single_pixel_plane();
        set_geometry(0, 0);
        send_item(CMD_DRAIN, 8'hFF);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'hA5);
        send_item(CMD_DRAIN, 8'h00);
    endtask

    // extreme pixel values against all four replicated edges
    task automatic test_edge_replication();
        set_geometry(3, 2);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'h5A);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_PIXEL, 8'h7F);
        send_item(CMD_DRAIN, 8'h80);
        send_item(CMD_DRAIN, 8'hFF);
    endtask

    // oversized register values clamp; a write mid-plane restarts the raster
    task automatic test_restart_mid_plane();
        set_geometry(511, 8191);
        repeat (3) send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
        set_geometry(1, 4096);
        repeat (4) send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
        set_geometry(2, 2);
        repeat (4) send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
        repeat (3) send_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
    endtask

    // mostly complete planes of random size and content; now and then a
    // plane is cut short, a stray drain slips in, or a flush step carries
    // a pixel. One full-width plane is included.
    task automatic test_random_planes();
        int unsigned sent, w, h, wval, hval, npix, plane, r;
        bit aborted, big_done, cut;
        sent = 0;
        w = 1;
        h = 1;
        plane = 0;
        aborted = 1'b1;
        big_done = 1'b0;
        while (sent < 1900)
        begin
            if (aborted || (!big_done && plane == 4) || $urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 99);
                if (!big_done && plane == 4)
                begin
                    w = MAX_WIDTH;
                    h = 2;
                    big_done = 1'b1;
                end
                else
                begin
                    if (r < 70)
                        w = $urandom_range(1, 8);
                    else if (r < 95)
                        w = $urandom_range(9, 40);
                    else
                        w = $urandom_range(41, 200);
                    h = (w > 40) ? $urandom_range(1, 2) : $urandom_range(1, 8);
                end
                wval = w;
                if (w == 1 && $urandom_range(0, 1))
                    wval = 0;
                if (w == MAX_WIDTH && $urandom_range(0, 1))
                    wval = $urandom_range(MAX_WIDTH + 1, 511);
                hval = h;
                if (h == 1 && $urandom_range(0, 1))
                    hval = 0;
                set_geometry(wval, hval);
            end
            cut = ($urandom_range(0, 19) == 0);
            npix = cut ? $urandom_range(0, w * h) : w * h;
            for (int k = 0; k < npix; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
                send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
                sent++;
            end
            if (!cut)
            begin
                for (int k = 0; k <= w; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
                    else
                        send_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
                    sent++;
                end
            end
            aborted = cut;
            plane++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests, then wait for the pipeline to
    // empty and report.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_single_pixel_plane();
        test_edge_replication();
        test_restart_mid_plane();
        test_random_planes();
        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        mismatches += blurred_queue.size();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### gaussian_blur_3x3_stream_top.f
rtl/gb3_pkg.sv
rtl/gb3_regs.sv
rtl/gb3_seq.sv
rtl/gb3_line_store.sv
rtl/gb3_out.sv
rtl/gaussian_blur_3x3_stream_top.sv
tb/sv/testbench.sv
